[rtl/core/afs_pkg.sv]
// ============================================================================
// afs_pkg: shared types and codes for the ASK frame serializer
// Command, mode and carrier codes plus fixed frame constants.
// ============================================================================
package afs_pkg;

  // Input field widths
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 4;
  localparam int BYTE_W8 = 8;
  localparam int LEN_W   = 5;

  // Payload store depth follows the index field
  localparam int STORE_DEPTH = 1 << IDX_W;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CARRIER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEBUG   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd5;

  // Transmit modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_SENDING = 2'd1;
  localparam logic [1:0] MODE_CARRIER = 2'd2;
  localparam logic [1:0] MODE_DEBUG   = 2'd3;

  // Carrier selection codes
  localparam logic [1:0] CAR_SILENT = 2'd0;
  localparam logic [1:0] CAR_BURST  = 2'd1;
  localparam logic [1:0] CAR_CONT   = 2'd2;

  // Frame constants
  localparam logic [7:0] HEADER_BYTE   = 8'hAA;
  localparam logic [7:0] DEBUG_BYTE    = 8'h55;
  localparam logic [7:0] DEBUG_LEN     = 8'h01;
  localparam int         BITS_PER_BYTE = 10;
  localparam int         STOP_SLOT     = BITS_PER_BYTE - 1;

  typedef logic [7:0] byte_t;

endpackage

[rtl/core/ask_frame_serializer_unit.sv]
// ============================================================================
// ask_frame_serializer_unit: on-off keyed frame transmitter
// Builds header/length/payload/checksum frames and steps them out one bit per
// tick as UART-style bytes, reporting the selected carrier per command.
// ============================================================================
// Every command produces exactly one result beat. The block takes one command
// per clock; each command passes the input register, then the result register.
// All the work of a command (store write, frame build with its XOR checksum
// tree, bit selection and position advance) sits between those two registers.
// The input register lets a new command in while a finished result is still
// waiting on out_tready; the stream only stops when both stages are full.
module ask_frame_serializer_unit
  import afs_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 16,
  parameter int SILENCE_BITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  // command stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] data_index, [11:4] data_byte,
                                  // [16:12] payload_length, [23:17] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [1:0] carrier_select, [2] busy_res,
                                  // [7:3] zero
  output logic        out_tlast   // frame_done
);

  // Derived sizes
  localparam int FB_DEPTH = MAX_PAYLOAD + 3;
  localparam int FB_IW    = $clog2(FB_DEPTH);
  localparam int BYTE_W   = $clog2(MAX_PAYLOAD + 4);
  localparam int CNT_W    = $clog2(MAX_PAYLOAD + 1);
  localparam int SLOT_MAX = (SILENCE_BITS > BITS_PER_BYTE) ? SILENCE_BITS : BITS_PER_BYTE;
  localparam int SLOT_W   = $clog2(SLOT_MAX);
  localparam int SIL_LAST = (SILENCE_BITS > 0) ? SILENCE_BITS - 1 : 0;

  // Handshake state
  logic in_valid_r, in_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic adv;

  // Input register payload
  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  byte_t            byte_r;
  logic [LEN_W-1:0] len_r;

  // Block state
  byte_t              store_r [STORE_DEPTH];
  byte_t              store_nxt [STORE_DEPTH];
  byte_t              fbuf_r [FB_DEPTH];
  byte_t              fbuf_nxt [FB_DEPTH];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [BYTE_W-1:0]  bpos_r, bpos_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         car_r, car_nxt;

  // Result register
  logic [1:0] res_car_r;
  logic       res_busy_r;
  logic       res_done_r;
  logic       done;

  // Frame build and bit selection helpers
  logic [CNT_W-1:0]  n_new;
  byte_t             cs;
  logic [BYTE_W-1:0] nbytes;
  logic [SLOT_W-1:0] slot_m1;
  byte_t             cur_byte;
  logic              in_frame;
  logic              tx_bit;
  logic              last_bit;

  // Stage flow: result register drains, input register refills
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || adv;
  assign in_valid_nxt  = in_tready ? in_tvalid : in_valid_r;
  assign out_valid_nxt = adv ? in_valid_r : out_valid_r;

  // Clamp length and form the checksum over header, length and payload
  always_comb begin
    if (len_r > LEN_W'(MAX_PAYLOAD)) begin
      n_new = CNT_W'(MAX_PAYLOAD);
    end else begin
      n_new = CNT_W'(len_r);
    end
    cs = HEADER_BYTE ^ 8'(n_new);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i < int'(n_new)) begin
        cs = cs ^ store_r[i];
      end
    end
  end

  // Pick the current line bit from the frame position
  assign nbytes   = BYTE_W'(cnt_r) + BYTE_W'(3);
  assign slot_m1  = slot_r - SLOT_W'(1);
  assign cur_byte = fbuf_r[bpos_r[FB_IW-1:0]];
  assign in_frame = bpos_r < nbytes;

  always_comb begin
    if (!in_frame) begin
      tx_bit = 1'b0;
    end else if (slot_r == SLOT_W'(0)) begin
      tx_bit = 1'b0;
    end else if (slot_r == SLOT_W'(STOP_SLOT)) begin
      tx_bit = 1'b1;
    end else begin
      tx_bit = cur_byte[slot_m1[2:0]];
    end
  end

  // Last bit of frame plus trailing silence
  always_comb begin
    if (SILENCE_BITS == 0) begin
      last_bit = (bpos_r == nbytes - BYTE_W'(1)) && (slot_r == SLOT_W'(STOP_SLOT));
    end else begin
      last_bit = (bpos_r == nbytes) && (slot_r == SLOT_W'(SIL_LAST));
    end
  end

  // Command decode and next state
  always_comb begin
    store_nxt = store_r;
    fbuf_nxt  = fbuf_r;
    cnt_nxt   = cnt_r;
    bpos_nxt  = bpos_r;
    slot_nxt  = slot_r;
    mode_nxt  = mode_r;
    car_nxt   = car_r;
    done      = 1'b0;
    case (cmd_r)
      CMD_WRITE: begin
        store_nxt[idx_r] = byte_r;
      end
      CMD_START: begin
        cnt_nxt     = n_new;
        fbuf_nxt[0] = HEADER_BYTE;
        fbuf_nxt[1] = 8'(n_new);
        for (int k = 2; k < FB_DEPTH; k++) begin
          if (int'(n_new) + 2 == k) begin
            fbuf_nxt[k] = cs;
          end else if (k - 2 < STORE_DEPTH) begin
            fbuf_nxt[k] = store_r[k-2];
          end else begin
            fbuf_nxt[k] = 8'h00;
          end
        end
        bpos_nxt = '0;
        slot_nxt = '0;
        mode_nxt = MODE_SENDING;
      end
      CMD_CARRIER: begin
        mode_nxt = MODE_CARRIER;
        car_nxt  = CAR_CONT;
      end
      CMD_STOP: begin
        mode_nxt = MODE_IDLE;
        car_nxt  = CAR_SILENT;
      end
      CMD_DEBUG: begin
        cnt_nxt     = CNT_W'(1);
        fbuf_nxt[0] = HEADER_BYTE;
        fbuf_nxt[1] = DEBUG_LEN;
        fbuf_nxt[2] = DEBUG_BYTE;
        fbuf_nxt[3] = HEADER_BYTE ^ DEBUG_LEN ^ DEBUG_BYTE;
        bpos_nxt    = '0;
        slot_nxt    = '0;
        mode_nxt    = MODE_DEBUG;
      end
      CMD_TICK: begin
        if (mode_r == MODE_CARRIER) begin
          car_nxt = CAR_CONT;
        end else if (mode_r == MODE_IDLE) begin
          car_nxt = CAR_SILENT;
        end else begin
          car_nxt = tx_bit ? CAR_BURST : CAR_SILENT;
          if (last_bit) begin
            // wrap in debug repeat, finish otherwise
            bpos_nxt = '0;
            slot_nxt = '0;
            if (mode_r != MODE_DEBUG) begin
              mode_nxt = MODE_IDLE;
              done     = 1'b1;
            end
          end else if (in_frame && slot_r == SLOT_W'(STOP_SLOT)) begin
            bpos_nxt = bpos_r + BYTE_W'(1);
            slot_nxt = '0;
          end else begin
            slot_nxt = slot_r + SLOT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bpos_r      <= '0;
      slot_r      <= '0;
      mode_r      <= MODE_IDLE;
      car_r       <= CAR_SILENT;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_r[i] <= 8'h00;
      end
      for (int k = 0; k < FB_DEPTH; k++) begin
        fbuf_r[k] <= 8'h00;
      end
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_valid_r && adv) begin
        cnt_r   <= cnt_nxt;
        bpos_r  <= bpos_nxt;
        slot_r  <= slot_nxt;
        mode_r  <= mode_nxt;
        car_r   <= car_nxt;
        store_r <= store_nxt;
        fbuf_r  <= fbuf_nxt;
      end
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r  <= in_tuser;
      idx_r  <= in_tdata[3:0];
      byte_r <= in_tdata[11:4];
      len_r  <= in_tdata[16:12];
    end
  end

  // Load the result beat
  always_ff @(posedge clk) begin
    if (in_valid_r && adv) begin
      res_car_r  <= car_nxt;
      res_busy_r <= (mode_nxt == MODE_SENDING) || (mode_nxt == MODE_DEBUG);
      res_done_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, res_busy_r, res_car_r};
  assign out_tlast  = res_done_r;

endmodule

[sim/afs_tx_checker.sv]
// ============================================================================
// afs_tx_checker: status checker for the ASK frame serializer
// Watches the command and status streams, keeps its own copy of the keyer
// state, predicts the status beat of every accepted command and compares it
// field by field with the beats the block returns, oldest first.
// ============================================================================
module afs_tx_checker
  import afs_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 16,
  parameter int SILENCE_BITS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [3:0] data_index, [11:4] data_byte,
                                  // [16:12] payload_length, [23:17] zero
  input  logic [2:0]  in_tuser,   // [2:0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [1:0] carrier_select, [2] busy_res,
                                  // [7:3] zero
  input  logic        out_tlast,  // frame_done
  output int          fail_count,
  output int          pending,
  output int          results_checked,
  output int          frames_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic [1:0] carrier;
    logic       busy;
    logic       done;
  } tx_status_t;

  // Shadow of the keyer state
  byte_t      store_mem [STORE_DEPTH];
  byte_t      frame_buf [MAX_PAYLOAD+3];
  int         pay_cnt;
  int         bit_pos;
  logic [1:0] mode_q;
  logic [1:0] carrier_q;

  tx_status_t status_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_PRINTED)
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Apply one command to the shadow state and return the status it produces
  task automatic advance_keyer(input logic [2:0] cmd, input logic [3:0] idx,
                               input byte_t val, input logic [4:0] len,
                               output tx_status_t res);
    int    n;
    int    frame_bits;
    int    slot;
    byte_t chk;
    logic  done;
    done = 1'b0;
    case (cmd)
      CMD_WRITE: begin
        store_mem[idx] = val;
      end
      CMD_START: begin
        n = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(len);
        pay_cnt = n;
        frame_buf[0] = HEADER_BYTE;
        frame_buf[1] = byte_t'(n);
        for (int i = 0; i < n; i++) frame_buf[2+i] = store_mem[i];
        chk = '0;
        for (int i = 0; i < n + 2; i++) chk ^= frame_buf[i];
        frame_buf[n+2] = chk;
        bit_pos = 0;
        mode_q  = MODE_SENDING;
      end
      CMD_CARRIER: begin
        mode_q    = MODE_CARRIER;
        carrier_q = CAR_CONT;
      end
      CMD_STOP: begin
        mode_q    = MODE_IDLE;
        carrier_q = CAR_SILENT;
      end
      CMD_DEBUG: begin
        pay_cnt      = 1;
        frame_buf[0] = HEADER_BYTE;
        frame_buf[1] = DEBUG_LEN;
        frame_buf[2] = DEBUG_BYTE;
        frame_buf[3] = HEADER_BYTE ^ DEBUG_LEN ^ DEBUG_BYTE;
        bit_pos      = 0;
        mode_q       = MODE_DEBUG;
      end
      CMD_TICK: begin
        if (mode_q == MODE_CARRIER) begin
          carrier_q = CAR_CONT;
        end else if (mode_q == MODE_IDLE) begin
          carrier_q = CAR_SILENT;
        end else begin
          frame_bits = (pay_cnt + 3) * BITS_PER_BYTE;
          // start bit low, stop bit high, data LSB first, trailing silence low
          slot = bit_pos % BITS_PER_BYTE;
          if (bit_pos >= frame_bits || slot == 0)
            carrier_q = CAR_SILENT;
          else if (slot == STOP_SLOT)
            carrier_q = CAR_BURST;
          else
            carrier_q = frame_buf[bit_pos / BITS_PER_BYTE][slot-1] ? CAR_BURST : CAR_SILENT;
          bit_pos++;
          if (bit_pos >= frame_bits + SILENCE_BITS) begin
            // debug frames wrap and repeat; normal frames return to idle
            if (mode_q == MODE_DEBUG) begin
              bit_pos = 0;
            end else begin
              mode_q = MODE_IDLE;
              done   = 1'b1;
            end
          end
          bit_pos = bit_pos & 8'hFF;
        end
      end
      default: ;
    endcase
    res.carrier = carrier_q;
    res.busy    = (mode_q == MODE_SENDING) || (mode_q == MODE_DEBUG);
    res.done    = done;
  endtask

  always @(posedge clk) begin
    tx_status_t want;
    tx_status_t got_exp;
    if (!rst_n) begin
      foreach (store_mem[i]) store_mem[i] = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      pay_cnt         = 0;
      bit_pos         = 0;
      mode_q          = MODE_IDLE;
      carrier_q       = CAR_SILENT;
      status_q.delete();
      pending         = 0;
      fail_count      = 0;
      results_checked = 0;
      frames_done     = 0;
    end else begin
      // compare a returned beat before queuing this edge's command
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          report_mismatch("status beat with nothing expected", int'(out_tdata), 0);
        end else begin
          want = status_q.pop_front();
          results_checked++;
          if (want.done) frames_done++;
          if (out_tdata[1:0] !== want.carrier)
            report_mismatch("carrier_select", int'(out_tdata[1:0]), int'(want.carrier));
          if (out_tdata[2] !== want.busy)
            report_mismatch("busy_res", int'(out_tdata[2]), int'(want.busy));
          if (out_tlast !== want.done)
            report_mismatch("frame_done", int'(out_tlast), int'(want.done));
          if (out_tdata[7:3] !== 5'd0)
            report_mismatch("status pad bits", int'(out_tdata[7:3]), 0);
        end
      end
      if (in_tvalid && in_tready) begin
        advance_keyer(in_tuser, in_tdata[3:0], in_tdata[11:4], in_tdata[16:12], got_exp);
        status_q.push_back(got_exp);
      end
      pending = status_q.size();
    end
  end

endmodule

[sim/tb_ask_frame_serializer_unit.sv]
// ============================================================================
// tb_ask_frame_serializer_unit: testbench for the ASK frame serializer
// Drives directed commands and then random frame, carrier, debug and noise
// sequences with random gaps and result stalls; a checker predicts every
// status beat and the top reports the verdict.
// ============================================================================
module tb_ask_frame_serializer_unit
  import afs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 5;
  localparam int TOTAL_ITEMS  = 1400;
  localparam int DRAIN_EVERY  = 350;
  localparam int TAIL_CYCLES  = 8;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int MAX_PAYLOAD  = 16;
  localparam int SILENCE_BITS = 5;

  // command codes the block ignores
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = CMD_TICK;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  int fail_count;
  int pending;
  int results_checked;
  int frames_done;
  int items_sent  = 0;
  int cycle_count = 0;
  int stall_left  = 0;
  bit calm        = 1'b0;

  ask_frame_serializer_unit #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .SILENCE_BITS (SILENCE_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  afs_tx_checker #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .SILENCE_BITS (SILENCE_BITS)
  ) tx_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .frames_done     (frames_done)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // Gap length: mostly none or short, a few long; none in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one command beat after a random gap and hold it until accepted
  task automatic send_beat(input logic [2:0] cmd, input logic [3:0] idx,
                           input logic [7:0] val, input logic [4:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, len, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Command with random contents in the fields it does not use
  task automatic send_cmd(input logic [2:0] cmd);
    send_beat(cmd, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
              5'($urandom_range(0, 31)));
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_cmd(CMD_TICK);
  endtask

  // Hold the sender until every status beat has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, always ready in calm stretches
  always @(posedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else begin
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int kind;
    int r;
    int len;
    int nticks;
    int abandon_at;
    int next_drain;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle tick, store extremes, ignored codes, clamp, abandon paths
    send_beat(CMD_TICK, 4'h0, 8'h00, 5'd0);
    send_beat(CMD_WRITE, 4'h0, 8'hFF, 5'd0);
    send_beat(CMD_WRITE, 4'hF, 8'hFF, 5'd31);
    send_beat(CMD_WRITE, 4'h1, 8'h00, 5'd0);
    send_beat(CMD_UNUSED_LO, 4'h0, 8'h00, 5'd0);
    send_beat(CMD_UNUSED_HI, 4'hF, 8'hFF, 5'd31);
    send_beat(CMD_START, 4'h0, 8'h00, 5'd0);
    send_ticks(3);
    // store write while a frame is in flight must not touch it
    send_beat(CMD_WRITE, 4'h0, 8'h5A, 5'd0);
    send_ticks(1);
    send_cmd(CMD_CARRIER);
    send_ticks(1);
    send_cmd(CMD_STOP);
    send_beat(CMD_START, 4'hF, 8'hFF, 5'd31);
    send_ticks(2);
    send_cmd(CMD_DEBUG);
    send_ticks(2);
    send_cmd(CMD_STOP);
    send_ticks(1);
    drain_results();

    // Random sequences until the item budget is spent
    next_drain = items_sent + DRAIN_EVERY;
    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain += DRAIN_EVERY;
      end
      calm = ($urandom_range(0, 9) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        // full frame: load some bytes, start, tick to the end or abandon
        repeat ($urandom_range(0, 5)) begin
          r = $urandom_range(0, 15);
          if ($urandom_range(0, 1) == 0) r = r % 5;
          send_beat(CMD_WRITE, 4'(r), 8'($urandom_range(0, 255)),
                    5'($urandom_range(0, 31)));
        end
        r = $urandom_range(0, 99);
        len = (r < 75) ? $urandom_range(0, 4) :
              (r < 93) ? $urandom_range(5, 16) : $urandom_range(17, 31);
        send_beat(CMD_START, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                  5'(len));
        if (len > MAX_PAYLOAD) len = MAX_PAYLOAD;
        nticks = (len + 3) * BITS_PER_BYTE + SILENCE_BITS;
        abandon_at = ($urandom_range(0, 99) < 15) ? $urandom_range(0, nticks - 1) : nticks;
        for (int t = 0; t < nticks; t++) begin
          if (t == abandon_at) begin
            case ($urandom_range(0, 3))
              0:       send_cmd(CMD_STOP);
              1:       send_cmd(CMD_CARRIER);
              2:       send_cmd(CMD_DEBUG);
              default: send_cmd(CMD_START);
            endcase
            break;
          end
          if ($urandom_range(0, 99) < 4) send_cmd(CMD_WRITE);
          send_cmd(CMD_TICK);
        end
      end else if (kind < 72) begin
        // continuous carrier for a few ticks
        send_cmd(CMD_CARRIER);
        send_ticks($urandom_range(1, 6));
        if ($urandom_range(0, 1) == 0) send_cmd(CMD_STOP);
      end else if (kind < 82) begin
        // debug repeat, mostly long enough to wrap around at least once
        send_cmd(CMD_DEBUG);
        send_ticks($urandom_range(40, 100));
        if ($urandom_range(0, 1) == 0) send_cmd(CMD_STOP);
        else send_cmd(CMD_CARRIER);
      end else begin
        // noise: any code, any field values
        repeat ($urandom_range(1, 8)) send_cmd(3'($urandom_range(0, 7)));
      end
    end

    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands over frame, carrier, debug and noise sequences,",
             items_sent);
    $display("with %0d status beats checked and %0d frames sent to completion.",
             results_checked, frames_done);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
